[src/cvbl_pkg.sv]
// ============================================================================
// cvbl_pkg: shared types and constants of the volume block locator
// Holds the table depth, field widths, status and request codes, and the
// token that travels down the row of extent cells.
// ============================================================================
package cvbl_pkg;

  // Table depth and the width of a cell's own slot number.
  localparam int MAX_EXTENTS = 64;
  localparam int CELL_W      = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  // Field widths fixed by the interface.
  localparam int ACT_W    = 7;
  localparam int HDR_W    = 16;
  localparam int IDX_W    = 6;
  localparam int WORD_W   = 32;
  localparam int VBLOCK_W = 40;
  localparam int REM_W    = VBLOCK_W + 1;
  localparam int ADDR_W   = 3;
  localparam int APB_W    = 32;

  // Request codes.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOCATE = 1'b1;

  // Configuration register indexes, decoded from paddr[2].
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_HEADER = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_LOCATED = 2'd0,
    ST_RANGE   = 2'd1,
    ST_WRITTEN = 2'd2
  } status_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] size;
    logic [WORD_W-1:0] handle;
  } wr_t;

  // Lookup token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              done;
    status_t           status;
    logic [REM_W-1:0]  rem;
    logic [WORD_W-1:0] want;
    logic [WORD_W-1:0] handle;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] left;
  } tok_t;

endpackage

[src/cvbl_ifs.sv]
// ============================================================================
// cvbl_ifs: request and response channels of the volume block locator
// Valid/ready channels; a transaction completes when both are high.
// ============================================================================
interface cvbl_req_if;
  import cvbl_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [IDX_W-1:0]    entry_index;
  logic [WORD_W-1:0]   entry_size;
  logic [WORD_W-1:0]   entry_handle;
  logic [VBLOCK_W-1:0] volume_block;
  logic [WORD_W-1:0]   want_blocks;

  modport source (
    output valid, req_type, entry_index, entry_size, entry_handle,
           volume_block, want_blocks,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_size, entry_handle,
           volume_block, want_blocks,
    output ready
  );
endinterface

interface cvbl_rsp_if;
  import cvbl_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [WORD_W-1:0] found_handle;
  logic [WORD_W-1:0] extent_offset;
  logic [WORD_W-1:0] run_blocks;

  modport source (
    output valid, status, found_handle, extent_offset, run_blocks,
    input  ready
  );
  modport sink (
    input  valid, status, found_handle, extent_offset, run_blocks,
    output ready
  );
endinterface

[src/cvbl_cell.sv]
// ============================================================================
// cvbl_cell: one extent slot of the locator
// Stores one extent's size and descriptor; each cycle it takes the lookup
// token from its left neighbour, resolves it as out of range or within its
// own extent or else subtracts its size, and registers it for the next cell.
// ============================================================================
module cvbl_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [cvbl_pkg::CELL_W-1:0] cell_idx,
  input  logic [cvbl_pkg::ACT_W-1:0]  active_entries,
  input  cvbl_pkg::wr_t         wr,
  input  cvbl_pkg::tok_t        tok_in,
  output cvbl_pkg::tok_t        tok_out
);
  import cvbl_pkg::*;

  logic [WORD_W-1:0] size;
  logic [WORD_W-1:0] handle;
  logic              tok_valid;
  tok_t              tok;
  tok_t              tok_next;
  logic              beyond_active;
  logic              hit;

  // Entry storage, written when the broadcast slot matches this cell.
  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.index) == 32'(cell_idx))) begin
      size   <= wr.size;
      handle <= wr.handle;
    end
  end

  // The token is resolved here if this slot is past the active count, or
  // if the remaining offset falls within this extent.
  assign beyond_active = 32'(cell_idx) >= 32'(active_entries);
  assign hit           = REM_W'(size) > tok_in.rem;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.done) begin
      if (beyond_active) begin
        tok_next.done   = 1'b1;
        tok_next.status = ST_RANGE;
        tok_next.handle = '0;
        tok_next.offset = '0;
        tok_next.left   = '0;
      end else if (hit) begin
        tok_next.done   = 1'b1;
        tok_next.status = ST_LOCATED;
        tok_next.handle = handle;
        tok_next.offset = tok_in.rem[WORD_W-1:0];
        tok_next.left   = size - tok_in.rem[WORD_W-1:0];
      end else begin
        tok_next.rem = tok_in.rem - REM_W'(size);
      end
    end
  end

  // Token stage towards the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok <= tok_next;
  end

  always_comb begin
    tok_out       = tok;
    tok_out.valid = tok_valid;
  end

endmodule

[src/concat_volume_block_locator.sv]
// ============================================================================
// concat_volume_block_locator: extent table and linear volume block lookup
// Writes extent table entries and maps volume blocks onto extents through a
// row of extent cells.
// ============================================================================
// The block takes one transaction at a time. Every transaction, table write
// or lookup, enters a head stage and then passes through the row of
// MAX_EXTENTS extent cells, one cell per cycle, then a tail stage and the
// output register, where its result is held until taken. A new request is
// accepted as soon as the previous result has reached the output register,
// even if it has not yet been taken.
// Table writes take effect at acceptance and answer with the written status.
// Configuration writes through the APB port must only be made while the
// block is idle; a lookup must not walk over a table entry never written.
module concat_volume_block_locator (
  input  logic                        clk,
  input  logic                        rst,
  cvbl_req_if.sink                    req,
  cvbl_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cvbl_pkg::ADDR_W-1:0] paddr,
  input  logic [cvbl_pkg::APB_W-1:0]  pwdata,
  output logic [cvbl_pkg::APB_W-1:0]  prdata,
  output logic                        pready
);
  import cvbl_pkg::*;

  logic [ACT_W-1:0]  active_entries;
  logic [HDR_W-1:0]  header_blocks;
  logic              cfg_wr;
  logic              accept;
  logic              busy;
  logic              head_valid;
  tok_t              head;
  wr_t               wr;
  tok_t              chain [MAX_EXTENTS+1];
  logic              tail_valid;
  tok_t              tail;
  logic              tail_move;
  logic              out_valid;
  status_t           out_status;
  logic [WORD_W-1:0] out_handle;
  logic [WORD_W-1:0] out_offset;
  logic [WORD_W-1:0] out_run;
  logic [MAX_EXTENTS-1:0] cell_valid;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACT_W'(0);
      header_blocks  <= HDR_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACTIVE: active_entries <= pwdata[ACT_W-1:0];
        REG_HEADER: header_blocks  <= pwdata[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACTIVE: prdata = APB_W'(active_entries);
      REG_HEADER: prdata = APB_W'(header_blocks);
      default:    prdata = '0;
    endcase
  end

  // Request acceptance: one transaction in flight until it reaches the
  // output register.
  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (tail_move) begin
      busy <= 1'b0;
    end
  end

  // Table write broadcast, done at acceptance.
  always_comb begin
    wr.en     = accept && (req.req_type == REQ_WRITE)
                && (32'(req.entry_index) < MAX_EXTENTS);
    wr.index  = req.entry_index;
    wr.size   = req.entry_size;
    wr.handle = req.entry_handle;
  end

  // Head stage: builds the token; a write enters already resolved.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else begin
      head_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head.valid  <= 1'b1;
      head.done   <= (req.req_type == REQ_WRITE);
      head.status <= ST_WRITTEN;
      head.rem    <= REM_W'(req.volume_block) + REM_W'(header_blocks);
      head.want   <= req.want_blocks;
      head.handle <= '0;
      head.offset <= '0;
      head.left   <= '0;
    end
  end

  always_comb begin
    chain[0]       = head;
    chain[0].valid = head_valid;
  end

  // Row of extent cells.
  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    cvbl_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cell_idx       (CELL_W'(i)),
      .active_entries (active_entries),
      .wr             (wr),
      .tok_in         (chain[i]),
      .tok_out        (chain[i+1])
    );
    assign cell_valid[i] = chain[i+1].valid;
  end

  // Tail stage: a token still unresolved past the last cell is out of range.
  assign tail_move = tail_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_valid <= 1'b0;
    end else if (chain[MAX_EXTENTS].valid) begin
      tail_valid <= 1'b1;
    end else if (tail_move) begin
      tail_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chain[MAX_EXTENTS].valid) begin
      tail <= chain[MAX_EXTENTS];
      if (!chain[MAX_EXTENTS].done) begin
        tail.status <= ST_RANGE;
        tail.handle <= '0;
        tail.offset <= '0;
        tail.left   <= '0;
      end
    end
  end

  // Output register: the run is the request clipped to the room left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tail_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_move) begin
      out_status <= tail.status;
      out_handle <= tail.handle;
      out_offset <= tail.offset;
      out_run    <= (tail.left >= tail.want) ? tail.want : tail.left;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.found_handle  = out_handle;
  assign rsp.extent_offset = out_offset;
  assign rsp.run_blocks    = out_run;

`ifndef SYNTH
  // Only one token is ever in flight between head and tail.
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({head_valid, cell_valid, tail_valid}))
    else $error("more than one token in the cell row");

  // An accepted request keeps the block busy until its result is output.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted but block not busy");

  // Nothing may be left in the row or tail once the block is idle.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!tail_valid && !head_valid && (cell_valid == '0)))
    else $error("token present while block idle");

  // A tail result waiting on a full output register must not be lost.
  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    (tail_valid && out_valid && !rsp.ready) |=> tail_valid)
    else $error("tail result dropped while output stalled");
`endif

endmodule
